>>> rtl/core/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int MODE_W = 2;
  localparam int ID_W   = 8;
  localparam int EXP_W  = 32;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_ADJUST = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  // One timer as it sits in the sorted list.
  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  ident;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

>>> rtl/core/stq_in_if.sv
`timescale 1ns / 1ps

interface stq_in_if import stq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   timer_id;
  logic [EXP_W-1:0]  expire_time;
  logic [TAG_W-1:0]  user_tag;
  logic [EXP_W-1:0]  now_time;

  modport source (
    output valid, mode, timer_id, expire_time, user_tag, now_time,
    input  ready
  );

  modport sink (
    input  valid, mode, timer_id, expire_time, user_tag, now_time,
    output ready
  );
endinterface

>>> rtl/core/stq_out_if.sv
`timescale 1ns / 1ps

interface stq_out_if import stq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  expired_tag;
  logic              last;

  modport source (
    output valid, status, expired_tag, last,
    input  ready
  );

  modport sink (
    input  valid, status, expired_tag, last,
    output ready
  );
endinterface

>>> rtl/core/stq_store.sv
`timescale 1ns / 1ps

module stq_store import stq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  entry_t                      wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output entry_t                      rd_data
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads so a stalled step can keep using it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/stq_cmp.sv
`timescale 1ns / 1ps

module stq_cmp import stq_pkg::*; (
  input  logic [EXP_W-1:0] entry_expiry,
  input  logic [EXP_W-1:0] key_time,
  input  logic [ID_W-1:0]  entry_ident,
  input  logic [ID_W-1:0]  key_ident,
  output logic             time_le,
  output logic             ident_eq
);

  assign time_le  = (entry_expiry <= key_time);
  assign ident_eq = (entry_ident == key_ident);

endmodule

>>> rtl/core/sorted_timer_queue_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                                            Transfer
// in_ch    in   mode, timer_id, expire_time, user_tag, now_time    valid & ready
// out_ch   out  status, expired_tag, last                          valid & ready
//
// The list lives in a single-port-read, single-port-write memory; every step of
// a search or a shift is a read state followed by a compare/write state.
// Add moves each later entry back one place; delete and adjust scan entries
// and then shift the later ones forward (adjust adds an insert pass).
// Tick reads each expired timer, then compacts the surviving entries.
// Synchronous reset empties the list; input is taken only in the idle state,
// and a stalled output holds the sequencer at the step that produces a result.

module sorted_timer_queue_top import stq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_INS_RD  = 12'b0000_0000_0010,
    S_INS_EV  = 12'b0000_0000_0100,
    S_FIND_RD = 12'b0000_0000_1000,
    S_FIND_EV = 12'b0000_0001_0000,
    S_DEL_RD  = 12'b0000_0010_0000,
    S_DEL_EV  = 12'b0000_0100_0000,
    S_TICK_RD = 12'b0000_1000_0000,
    S_TICK_EV = 12'b0001_0000_0000,
    S_TICK_END = 12'b0010_0000_0000,
    S_CMP_RD  = 12'b0100_0000_0000,
    S_CMP_EV  = 12'b1000_0000_0000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  idx_inc;
  mode_t             cur_mode;
  logic [ID_W-1:0]   cur_id;
  logic [EXP_W-1:0]  cur_exp;
  logic [EXP_W-1:0]  cur_now;
  logic [TAG_W-1:0]  ins_tag;
  status_t           rsp_status;
  logic              reply_pending;
  logic              pend_valid;
  logic [TAG_W-1:0]  pend_tag;

  logic              out_valid;
  status_t           out_status;
  logic [TAG_W-1:0]  out_tag;
  logic              out_last;
  logic              out_free;
  logic              out_load;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  entry_t            new_entry;
  logic [EXP_W-1:0]  key_time;
  logic              time_le;
  logic              ident_eq;
  mode_t             in_mode;

  assign in_mode   = mode_t'(in_ch.mode);
  assign idx_inc   = idx + CNT_W'(1);
  assign out_free  = !out_valid || out_ch.ready;
  assign new_entry = '{expiry: cur_exp, ident: cur_id, tag: ins_tag};
  assign key_time  = (state == S_TICK_EV) ? cur_now : cur_exp;

  // The output register takes a new result on exactly these steps.
  assign out_load = (reply_pending && out_free)
                 || (state == S_TICK_EV && time_le && pend_valid && out_free)
                 || (state == S_TICK_END && out_free);

  assign in_ch.ready        = (state == S_IDLE) && !reply_pending;
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.expired_tag = out_tag;
  assign out_ch.last        = out_last;

  stq_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stq_cmp u_cmp (
    .entry_expiry (rd_data.expiry),
    .key_time     (key_time),
    .entry_ident  (rd_data.ident),
    .key_ident    (cur_id),
    .time_le      (time_le),
    .ident_eq     (ident_eq)
  );

  // Memory port steering for each sequencer step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      S_INS_RD: begin
        if (pos == '0) begin
          wr_en   = 1'b1;
          wr_data = new_entry;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(pos - CNT_W'(1));
        end
      end
      S_INS_EV: begin
        // Later entries move back one place until the insertion point shows up.
        wr_en   = 1'b1;
        wr_addr = pos[IDX_W-1:0];
        wr_data = time_le ? new_entry : rd_data;
      end
      S_FIND_RD, S_TICK_RD, S_CMP_RD: begin
        rd_en   = (idx != count);
        rd_addr = idx[IDX_W-1:0];
      end
      S_DEL_RD: begin
        rd_en   = (idx_inc != count);
        rd_addr = idx_inc[IDX_W-1:0];
      end
      S_DEL_EV: begin
        wr_en   = 1'b1;
        wr_addr = idx[IDX_W-1:0];
      end
      S_CMP_EV: begin
        wr_en   = 1'b1;
        wr_addr = pos[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      reply_pending <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // Single-result replies wait here for the output register.
      if (reply_pending && out_free) begin
        out_status    <= rsp_status;
        out_tag       <= '0;
        out_last      <= 1'b1;
        reply_pending <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && !reply_pending) begin
            cur_mode   <= in_mode;
            cur_id     <= in_ch.timer_id;
            cur_exp    <= in_ch.expire_time;
            cur_now    <= in_ch.now_time;
            ins_tag    <= in_ch.user_tag;
            idx        <= '0;
            pend_valid <= 1'b0;
            unique case (in_mode) inside
              MODE_ADD: begin
                if (count == CNT_W'(CAPACITY)) begin
                  rsp_status    <= ST_FULL;
                  reply_pending <= 1'b1;
                end else begin
                  pos   <= count;
                  state <= S_INS_RD;
                end
              end
              MODE_ADJUST, MODE_DELETE: state <= S_FIND_RD;
              default: state <= S_TICK_RD;
            endcase
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count         <= count + CNT_W'(1);
            rsp_status    <= ST_OK;
            reply_pending <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_INS_EV;
          end
        end
        S_INS_EV: begin
          if (time_le) begin
            count         <= count + CNT_W'(1);
            rsp_status    <= ST_OK;
            reply_pending <= 1'b1;
            state         <= S_IDLE;
          end else begin
            pos   <= pos - CNT_W'(1);
            state <= S_INS_RD;
          end
        end
        S_FIND_RD: begin
          if (idx == count) begin
            rsp_status    <= ST_NOT_FOUND;
            reply_pending <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_FIND_EV;
          end
        end
        S_FIND_EV: begin
          if (ident_eq) begin
            ins_tag <= rd_data.tag;
            state   <= S_DEL_RD;
          end else begin
            idx   <= idx_inc;
            state <= S_FIND_RD;
          end
        end
        S_DEL_RD: begin
          if (idx_inc == count) begin
            count <= count - CNT_W'(1);
            if (cur_mode == MODE_ADJUST) begin
              pos   <= count - CNT_W'(1);
              state <= S_INS_RD;
            end else begin
              rsp_status    <= ST_OK;
              reply_pending <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_DEL_EV;
          end
        end
        S_DEL_EV: begin
          idx   <= idx_inc;
          state <= S_DEL_RD;
        end
        S_TICK_RD: begin
          state <= (idx == count) ? S_TICK_END : S_TICK_EV;
        end
        S_TICK_EV: begin
          // The previous expired tag goes out only once another one is known,
          // so the final one can carry the last marker.
          if (time_le) begin
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                out_status <= ST_EXPIRED;
                out_tag    <= pend_tag;
                out_last   <= 1'b0;
              end
              pend_tag   <= rd_data.tag;
              pend_valid <= 1'b1;
              idx        <= idx_inc;
              state      <= S_TICK_RD;
            end
          end else begin
            state <= S_TICK_END;
          end
        end
        S_TICK_END: begin
          if (out_free) begin
            out_status <= pend_valid ? ST_EXPIRED : ST_NONE;
            out_tag    <= pend_valid ? pend_tag : '0;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            pos        <= '0;
            state      <= (idx == '0) ? S_IDLE : S_CMP_RD;
          end
        end
        S_CMP_RD: begin
          if (idx == count) begin
            count <= pos;
            state <= S_IDLE;
          end else begin
            state <= S_CMP_EV;
          end
        end
        S_CMP_EV: begin
          pos   <= pos + CNT_W'(1);
          idx   <= idx_inc;
          state <= S_CMP_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("timer count exceeds capacity");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_EXPIRED) |-> (out_last && out_tag == '0))
    else $error("status result without last marker or with a tag");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_mode == MODE_ADD && count == CNT_W'(CAPACITY))
    |=> (count == $past(count)))
    else $error("add on a full list changed the count");

endmodule
